[src/lfts_pkg.sv]
// Shared types and constants for the trimmed-mean level switch.
// Holds register indexes, command codes, default sizes and the datapath control structs.
// No dependencies.
package lfts_pkg;

    // Default window geometry.
    localparam int DefWindowSize = 10;
    localparam int DefFirstKept  = 3;
    localparam int DefKeptCount  = 5;

    // Field widths that the frame format fixes.
    localparam int ByteW   = 8;
    localparam int LevelW  = 16;
    localparam int TrimW   = 19;
    localparam int CmdW    = 2;

    // Configuration port geometry.
    localparam int NumRegs   = 5;
    localparam int PaddrW    = $clog2(NumRegs * 4);
    localparam int RegIdxW   = PaddrW - 2;
    localparam int PdataW    = 32;

    localparam logic [RegIdxW-1:0] REG_CMD_ENABLE = RegIdxW'(0);
    localparam logic [RegIdxW-1:0] REG_FULL_LIMIT = RegIdxW'(1);
    localparam logic [RegIdxW-1:0] REG_FAULT_LIMIT = RegIdxW'(2);
    localparam logic [RegIdxW-1:0] REG_START_LOW  = RegIdxW'(3);
    localparam logic [RegIdxW-1:0] REG_START_HIGH = RegIdxW'(4);

    // Reset values of the configuration registers.
    localparam logic [LevelW-1:0] RstFullLimit  = LevelW'(80);
    localparam logic [LevelW-1:0] RstFaultLimit = LevelW'(1100);
    localparam logic [LevelW-1:0] RstStartLow   = LevelW'(680);
    localparam logic [LevelW-1:0] RstStartHigh  = LevelW'(1150);

    // Switch command codes.
    localparam logic [CmdW-1:0] CMD_NONE = CmdW'(0);
    localparam logic [CmdW-1:0] CMD_OFF  = CmdW'(1);
    localparam logic [CmdW-1:0] CMD_ON   = CmdW'(2);

    typedef struct packed {
        logic              cmd_enable;
        logic [LevelW-1:0] full_limit;
        logic [LevelW-1:0] fault_limit;
        logic [LevelW-1:0] start_low;
        logic [LevelW-1:0] start_high;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the frame of the accepted beat
        logic store;      // shift the frame's level into the window
        logic eval;       // the accepted frame triggers an evaluation
        logic sort_step;  // one odd-even transposition phase
        logic odd_phase;  // phase parity for sort_step
        logic sum_step;   // shift the window down by one entry
        logic sum_take;   // add the bottom entry to the sum
        logic out_load;   // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // result register can take a new result this cycle
    } t_dp_status;

endpackage

[src/lfts_ctrl.sv]
// Controller state machine for the trimmed-mean level switch.
// Tracks the window fill count and sequences sort, sum and result load.
// Depends on lfts_pkg.
module lfts_ctrl import lfts_pkg::*; #(
    parameter int WINDOW_SIZE = DefWindowSize,
    parameter int FIRST_KEPT  = DefFirstKept,
    parameter int KEPT_COUNT  = DefKeptCount
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int CntW      = $clog2(WINDOW_SIZE + 1);
    localparam int SumLast   = (FIRST_KEPT + KEPT_COUNT < WINDOW_SIZE) ?
                               (FIRST_KEPT + KEPT_COUNT) : WINDOW_SIZE;
    localparam int FirstClip = (FIRST_KEPT < WINDOW_SIZE) ? FIRST_KEPT : WINDOW_SIZE;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SORT = 4'b0010,
        S_SUM  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_step, n_step;
    logic            accept;
    logic            full;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign full       = (r_count == CntW'(WINDOW_SIZE));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.odd_phase = r_step[0];
        o_cmd.sum_take  = (r_step >= CntW'(FirstClip));
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.eval    = full;
                    n_step        = '0;
                    if (full) begin
                        n_state = S_SORT;
                    end else begin
                        o_cmd.store = 1'b1;
                        n_count     = r_count + CntW'(1);
                        n_state     = S_DONE;
                    end
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (r_step == CntW'(WINDOW_SIZE - 1)) begin
                    n_step  = '0;
                    n_state = S_SUM;
                end else begin
                    n_step = r_step + CntW'(1);
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (r_step == CntW'(SumLast - 1)) begin
                    n_step  = '0;
                    n_count = '0;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + CntW'(1);
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
        end
    end

    // A frame that arrives on a full window starts the sort.
    a_full_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full) |=> (r_state == S_SORT))
        else $error("full window did not start a sort");

    // The window never holds more than its size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(WINDOW_SIZE))
        else $error("fill count beyond window size");

    // An evaluation leaves the window empty.
    a_eval_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_step == CntW'(SumLast - 1)) |=> (r_count == '0))
        else $error("window not emptied after evaluation");

endmodule

[src/lfts_dp.sv]
// Datapath for the trimmed-mean level switch: frame check, sample window,
// odd-even transposition sort, serial trimmed sum, decision and result register.
// Depends on lfts_pkg.
module lfts_dp import lfts_pkg::*; #(
    parameter int WINDOW_SIZE = DefWindowSize,
    parameter int KEPT_COUNT  = DefKeptCount
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ByteW-1:0]  i_header_byte,
    input  logic [ByteW-1:0]  i_level_high,
    input  logic [ByteW-1:0]  i_level_low,
    input  logic [ByteW-1:0]  i_check_byte,
    input  t_cfg              i_cfg,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_checksum_ok,
    output logic [LevelW-1:0] o_sample_tenths,
    output logic              o_evaluated,
    output logic [TrimW-1:0]  o_trimmed_sum,
    output logic [CmdW-1:0]   o_command
);

    localparam int SumW = $clog2(KEPT_COUNT * ((1 << LevelW) - 1) + 1);
    localparam int ExtW = (SumW > TrimW) ? SumW : TrimW;

    logic [LevelW-1:0] r_store [WINDOW_SIZE];
    logic [LevelW-1:0] sort_next [WINDOW_SIZE];
    logic [ByteW-1:0]  frame_sum;
    logic              frame_ok;
    logic [LevelW-1:0] frame_level;
    logic              r_ok;
    logic [LevelW-1:0] r_level;
    logic              r_eval;
    logic [SumW-1:0]   r_sum;
    logic [SumW-1:0]   r_full_k, r_fault_k, r_low_k, r_high_k;
    logic [CmdW-1:0]   decision;
    logic [ExtW-1:0]   sum_ext;
    logic              r_out_valid;

    assign frame_sum   = i_header_byte + i_level_high + i_level_low;
    assign frame_ok    = (frame_sum == i_check_byte);
    assign frame_level = frame_ok ? {i_level_high, i_level_low} : '0;

    // One compare-exchange phase; each entry pairs with a fixed neighbor per parity.
    for (genvar gi = 0; gi < WINDOW_SIZE; gi++) begin : g_sort
        localparam bit Odd = (gi % 2) == 1;
        logic pair_up, pair_down;
        if (gi + 1 < WINDOW_SIZE) begin : g_up
            assign pair_up = (i_cmd.odd_phase == Odd);
        end else begin : g_no_up
            assign pair_up = 1'b0;
        end
        if (gi > 0) begin : g_down
            assign pair_down = (i_cmd.odd_phase != Odd);
        end else begin : g_no_down
            assign pair_down = 1'b0;
        end
        always_comb begin
            sort_next[gi] = r_store[gi];
            if (pair_up) begin
                if (r_store[gi] > r_store[(gi + 1) % WINDOW_SIZE]) begin
                    sort_next[gi] = r_store[(gi + 1) % WINDOW_SIZE];
                end
            end else if (pair_down) begin
                if (r_store[(gi + WINDOW_SIZE - 1) % WINDOW_SIZE] > r_store[gi]) begin
                    sort_next[gi] = r_store[(gi + WINDOW_SIZE - 1) % WINDOW_SIZE];
                end
            end
        end
    end

    // Window: shift-in on store, sort phase, or shift-down while summing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
                r_store[i] <= r_store[i + 1];
            end
            r_store[WINDOW_SIZE - 1] <= frame_level;
        end else if (i_cmd.sort_step) begin
            r_store <= sort_next;
        end else if (i_cmd.sum_step) begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
                r_store[i] <= r_store[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ok    <= frame_ok;
            r_level <= frame_level;
            r_eval  <= i_cmd.eval;
            r_sum   <= '0;
        end else if (i_cmd.sum_step && i_cmd.sum_take) begin
            r_sum <= r_sum + SumW'(r_store[0]);
        end
    end

    // Thresholds scaled by the kept count; refreshed every cycle.
    always_ff @(posedge i_clk) begin
        r_full_k  <= SumW'(KEPT_COUNT) * SumW'(i_cfg.full_limit);
        r_fault_k <= SumW'(KEPT_COUNT) * SumW'(i_cfg.fault_limit);
        r_low_k   <= SumW'(KEPT_COUNT) * SumW'(i_cfg.start_low);
        r_high_k  <= SumW'(KEPT_COUNT) * SumW'(i_cfg.start_high);
    end

    always_comb begin
        decision = CMD_NONE;
        if ((r_sum != '0 && r_sum < r_full_k) || r_sum > r_fault_k) begin
            decision = CMD_OFF;
        end else if (r_sum < r_high_k && r_sum > r_low_k) begin
            decision = CMD_ON;
        end
        if (!i_cfg.cmd_enable) begin
            decision = CMD_NONE;
        end
    end

    assign sum_ext           = ExtW'(r_sum);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_checksum_ok   <= r_ok;
            o_sample_tenths <= r_level;
            o_evaluated     <= r_eval;
            o_trimmed_sum   <= r_eval ? sum_ext[TrimW-1:0] : '0;
            o_command       <= r_eval ? decision : CMD_NONE;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while held");

    // Frames that did not evaluate carry no sum and no command.
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_evaluated) |-> (o_trimmed_sum == '0 && o_command == CMD_NONE))
        else $error("sum or command on a frame that did not evaluate");

endmodule

[src/level_frame_trimmed_mean_switch.sv]
// Top level of the trimmed-mean level switch: configuration registers and the
// controller and datapath instances.
// Depends on lfts_pkg, lfts_ctrl and lfts_dp.
//
// Each input beat is a four-byte sensor frame; the block checks its checksum, takes
// the 16-bit level (zero on a bad checksum) and returns exactly one result beat per
// frame. Until the window holds WINDOW_SIZE samples a frame's level is stored and
// its result is loaded once the output register is free; no new frame is taken
// before that load. A frame that meets a full window is not stored: the window is
// sorted by an odd-even transposition network, one compare-exchange phase per cycle,
// then shifted out one entry per cycle into an accumulator that adds sorted
// positions FIRST_KEPT up to FIRST_KEPT+KEPT_COUNT-1 (clipped to the window);
// the result is then loaded once the output register is free. The sum is
// compared with KEPT_COUNT times each threshold, giving the off, on or none command,
// which reads as none while commands are disabled; the window is then empty.
// The input channel is stalled while a frame is in work; a finished result waits in
// an output register, and a new frame is taken while it waits. Configuration
// registers sit at byte addresses 0, 4, 8, 12 and 16 and should be written only
// while the block is idle.
module level_frame_trimmed_mean_switch import lfts_pkg::*; #(
    parameter int WINDOW_SIZE = DefWindowSize,
    parameter int FIRST_KEPT  = DefFirstKept,
    parameter int KEPT_COUNT  = DefKeptCount
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [PdataW-1:0] pwdata,
    output logic [PdataW-1:0] prdata,
    output logic              pready,
    // Frame input channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ByteW-1:0]  i_header_byte,
    input  logic [ByteW-1:0]  i_level_high,
    input  logic [ByteW-1:0]  i_level_low,
    input  logic [ByteW-1:0]  i_check_byte,
    // Result output channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_checksum_ok,
    output logic [LevelW-1:0] o_sample_tenths,
    output logic              o_evaluated,
    output logic [TrimW-1:0]  o_trimmed_sum,
    output logic [CmdW-1:0]   o_command
);

    t_cfg              r_cfg;
    logic              cfg_write;
    logic [RegIdxW-1:0] reg_idx;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PaddrW-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Register writes take the low bits of the data; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_enable  <= 1'b0;
            r_cfg.full_limit  <= RstFullLimit;
            r_cfg.fault_limit <= RstFaultLimit;
            r_cfg.start_low   <= RstStartLow;
            r_cfg.start_high  <= RstStartHigh;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_CMD_ENABLE:  r_cfg.cmd_enable  <= pwdata[0];
                REG_FULL_LIMIT:  r_cfg.full_limit  <= pwdata[LevelW-1:0];
                REG_FAULT_LIMIT: r_cfg.fault_limit <= pwdata[LevelW-1:0];
                REG_START_LOW:   r_cfg.start_low   <= pwdata[LevelW-1:0];
                REG_START_HIGH:  r_cfg.start_high  <= pwdata[LevelW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CMD_ENABLE:  prdata = PdataW'(r_cfg.cmd_enable);
            REG_FULL_LIMIT:  prdata = PdataW'(r_cfg.full_limit);
            REG_FAULT_LIMIT: prdata = PdataW'(r_cfg.fault_limit);
            REG_START_LOW:   prdata = PdataW'(r_cfg.start_low);
            REG_START_HIGH:  prdata = PdataW'(r_cfg.start_high);
            default:         prdata = '0;
        endcase
    end

    // The controller owns the fill count and the sequencing.
    lfts_ctrl #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .FIRST_KEPT  (FIRST_KEPT),
        .KEPT_COUNT  (KEPT_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the window, the sort network, the sum and the result.
    lfts_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .KEPT_COUNT  (KEPT_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_header_byte   (i_header_byte),
        .i_level_high    (i_level_high),
        .i_level_low     (i_level_low),
        .i_check_byte    (i_check_byte),
        .i_cfg           (r_cfg),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_checksum_ok   (o_checksum_ok),
        .o_sample_tenths (o_sample_tenths),
        .o_evaluated     (o_evaluated),
        .o_trimmed_sum   (o_trimmed_sum),
        .o_command       (o_command)
    );

endmodule

[verif/tb_level_frame_trimmed_mean_switch.sv]
// Self-checking testbench for the trimmed-mean level switch.
// Holds a scoreboard class that predicts every result beat, plus the top module with the
// clock, reset, APB writes, frame sender, result receiver and watchdog. Depends on lfts_pkg.
`timescale 1ns / 1ps

module tb_level_frame_trimmed_mean_switch import lfts_pkg::*; ();

    typedef struct packed {
        logic              checksum_ok;
        logic [LevelW-1:0] sample_tenths;
        logic              evaluated;
        logic [TrimW-1:0]  trimmed_sum;
        logic [CmdW-1:0]   command;
    } t_frame_result;

    class level_switch_scoreboard;
        t_cfg              cfg;
        logic [LevelW-1:0] window_levels [DefWindowSize];
        int                held;
        t_frame_result     expected_results [$];
        int                errors;

        function new();
            cfg.cmd_enable  = 1'b0;
            cfg.full_limit  = RstFullLimit;
            cfg.fault_limit = RstFaultLimit;
            cfg.start_low   = RstStartLow;
            cfg.start_high  = RstStartHigh;
            held   = 0;
            errors = 0;
        endfunction

        // Only the low bits of the write data count; unknown indexes are dropped.
        function void set_register(logic [RegIdxW-1:0] idx, logic [PdataW-1:0] value);
            case (idx)
                REG_CMD_ENABLE:  cfg.cmd_enable  = value[0];
                REG_FULL_LIMIT:  cfg.full_limit  = value[LevelW-1:0];
                REG_FAULT_LIMIT: cfg.fault_limit = value[LevelW-1:0];
                REG_START_LOW:   cfg.start_low   = value[LevelW-1:0];
                REG_START_HIGH:  cfg.start_high  = value[LevelW-1:0];
                default: ;
            endcase
        endfunction

        // Works out the result of one accepted frame and queues it.
        function void note_frame(logic [ByteW-1:0] hdr, logic [ByteW-1:0] hi,
                                 logic [ByteW-1:0] lo, logic [ByteW-1:0] chk);
            logic [ByteW-1:0]  calc;
            logic [LevelW-1:0] ranked [DefWindowSize];
            logic [LevelW-1:0] swap;
            int unsigned       total;
            int unsigned       k;
            t_frame_result     r;
            calc = hdr + hi + lo;
            r.checksum_ok   = (calc == chk);
            r.sample_tenths = r.checksum_ok ? {hi, lo} : '0;
            r.evaluated     = 1'b0;
            r.trimmed_sum   = '0;
            r.command       = CMD_NONE;
            if (held < DefWindowSize) begin
                window_levels[held] = r.sample_tenths;
                held++;
            end else begin
                ranked = window_levels;
                for (int i = 0; i < DefWindowSize - 1; i++) begin
                    for (int j = i + 1; j < DefWindowSize; j++) begin
                        if (ranked[j] < ranked[i]) begin
                            swap      = ranked[i];
                            ranked[i] = ranked[j];
                            ranked[j] = swap;
                        end
                    end
                end
                total = 0;
                for (int i = DefFirstKept; i < DefFirstKept + DefKeptCount && i < DefWindowSize;
                     i++) begin
                    total += ranked[i];
                end
                k = DefKeptCount;
                if ((total > 0 && total < k * cfg.full_limit) ||
                    total > k * cfg.fault_limit) begin
                    r.command = CMD_OFF;
                end else if (total < k * cfg.start_high && total > k * cfg.start_low) begin
                    r.command = CMD_ON;
                end
                if (!cfg.cmd_enable) begin
                    r.command = CMD_NONE;
                end
                r.evaluated   = 1'b1;
                r.trimmed_sum = total[TrimW-1:0];
                held = 0;
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_results.size() == 0) begin
                $error("result beat arrived with no frame outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
            compare_field("sample_tenths", want.sample_tenths, got.sample_tenths);
            compare_field("evaluated", want.evaluated, got.evaluated);
            compare_field("trimmed_sum", want.trimmed_sum, got.trimmed_sum);
            compare_field("command", want.command, got.command);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // Cycles without any accepted beat or APB activity before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off plus an evaluation.
    localparam int WatchdogLimit = 2000;
    // Quiet cycles after the last result before a register write or the final verdict.
    // The margin over the time that an evaluating frame takes is ample.
    localparam int DrainCycles   = 40;
    localparam int HoldCycles    = 300;
    localparam int NumPhases     = 6;
    localparam int ItemsPerPhase = 250;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PaddrW-1:0] paddr;
    logic [PdataW-1:0] pwdata;
    logic [PdataW-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [ByteW-1:0]  i_header_byte;
    logic [ByteW-1:0]  i_level_high;
    logic [ByteW-1:0]  i_level_low;
    logic [ByteW-1:0]  i_check_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_checksum_ok;
    logic [LevelW-1:0] o_sample_tenths;
    logic              o_evaluated;
    logic [TrimW-1:0]  o_trimmed_sum;
    logic [CmdW-1:0]   o_command;

    level_switch_scoreboard sb;

    // Idle probabilities in percent, changed by the stimulus as the run moves on.
    int send_idle_pct;
    int recv_idle_pct;
    // Cycles left in a forced receiver hold-off; counted down by the receiver process.
    int hold_left;
    int quiet_cycles;
    // Position within the eleven-frame cycle of ten stores and one evaluation.
    int slot;
    int item_index;
    int center;

    level_frame_trimmed_mean_switch dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_header_byte   (i_header_byte),
        .i_level_high    (i_level_high),
        .i_level_low     (i_level_low),
        .i_check_byte    (i_check_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_checksum_ok   (o_checksum_ok),
        .o_sample_tenths (o_sample_tenths),
        .o_evaluated     (o_evaluated),
        .o_trimmed_sum   (o_trimmed_sum),
        .o_command       (o_command)
    );

    always #6 i_clk = ~i_clk;

    // Result receiver. Outputs are sampled at the edge, before any update that the edge
    // causes, and the next stall is scheduled with a single nonblocking assignment.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_checksum_ok, o_sample_tenths, o_evaluated, o_trimmed_sum,
                             o_command});
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any accepted beat or APB cycle counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("level_frame_trimmed_mean_switch: mismatch");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle held until pready.
    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [PdataW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Registers change only once the block has gone quiet. Upper data bits carry noise,
    // which the block must ignore.
    task automatic configure(input logic en, input logic [LevelW-1:0] full_lim,
                             input logic [LevelW-1:0] fault_lim,
                             input logic [LevelW-1:0] low_lim,
                             input logic [LevelW-1:0] high_lim);
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        write_reg(REG_CMD_ENABLE, {31'($urandom), en});
        write_reg(REG_FULL_LIMIT, {16'($urandom), full_lim});
        write_reg(REG_FAULT_LIMIT, {16'($urandom), fault_lim});
        write_reg(REG_START_LOW, {16'($urandom), low_lim});
        write_reg(REG_START_HIGH, {16'($urandom), high_lim});
    endtask

    // Offers one frame beat and waits for it to be taken. Valid stays high from one beat
    // to the next unless the sender decides to idle first.
    task automatic offer_frame(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] hi,
                               input logic [ByteW-1:0] lo, input logic [ByteW-1:0] chk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_header_byte <= hdr;
        i_level_high  <= hi;
        i_level_low   <= lo;
        i_check_byte  <= chk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_frame(hdr, hi, lo, chk);
    endtask

    // Builds a frame around a level, with a matching or a deliberately wrong check byte.
    task automatic send_level(input logic [ByteW-1:0] hdr, input logic [LevelW-1:0] lvl,
                              input bit good);
        logic [ByteW-1:0] chk;
        chk = hdr + lvl[15:8] + lvl[7:0];
        if (!good) begin
            chk = chk + 8'($urandom_range(1, 255));
        end
        offer_frame(hdr, lvl[15:8], lvl[7:0], chk);
    endtask

    // Windows are centered on a threshold half of the time, so that the trimmed sum lands
    // on and around every comparison boundary; otherwise on a field extreme or at random.
    function automatic int pick_center();
        case ($urandom_range(0, 7))
            0: return sb.cfg.full_limit;
            1: return sb.cfg.fault_limit;
            2: return sb.cfg.start_low;
            3: return sb.cfg.start_high;
            4: return 0;
            5: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_frame();
        int kind;
        int lvl;
        kind = $urandom_range(99);
        lvl  = center + $urandom_range(0, 6) - 3;
        if (lvl < 0) lvl = 0;
        if (lvl > 65535) lvl = 65535;
        if (kind < 5) begin
            // Raw noise: four random bytes, nearly always a bad checksum.
            offer_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (kind < 15) begin
            send_level(8'($urandom), 16'(lvl), 1'b0);
        end else if (kind < 27) begin
            // Outlier that the trimming should normally discard.
            send_level(8'($urandom), 16'($urandom), 1'b1);
        end else begin
            send_level(8'($urandom), 16'(lvl), 1'b1);
        end
    endtask

    initial begin
        sb = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_header_byte = '0;
        i_level_high  = '0;
        i_level_low   = '0;
        i_check_byte  = '0;
        send_idle_pct = 21;
        recv_idle_pct = 54;
        hold_left     = 0;
        quiet_cycles  = 0;
        slot          = 0;
        item_index    = 0;
        center        = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds with commands enabled. Writes past the last register must
        // leave every setting alone.
        configure(1'b1, RstFullLimit, RstFaultLimit, RstStartLow, RstStartHigh);
        for (int r = NumRegs; r < (1 << RegIdxW); r++) begin
            write_reg(RegIdxW'(r), $urandom);
        end

        // First window: field extremes, checksum wrap, bad frames storing zero and levels
        // equal to each threshold. The eleventh frame meets a full window, so it is
        // reported but never stored.
        send_level(8'h00, 16'h0000, 1'b1);
        send_level(8'hFF, 16'hFFFF, 1'b1);
        send_level(8'h5A, 16'h00FF, 1'b1);
        send_level(8'hA5, 16'hFF00, 1'b1);
        send_level(8'hFF, 16'hFFFF, 1'b0);
        offer_frame(8'h00, 8'h00, 8'h00, 8'hFF);
        send_level(8'h12, RstFullLimit, 1'b1);
        send_level(8'h34, RstFaultLimit, 1'b1);
        send_level(8'h56, RstStartLow, 1'b1);
        send_level(8'h78, RstStartHigh, 1'b1);
        send_level(8'h9C, 16'hFFFF, 1'b1);
        // Second window: every sample at full scale gives the largest possible sum, and
        // the evaluating frame itself has a bad checksum.
        for (int i = 0; i < DefWindowSize; i++) begin
            send_level(8'($urandom), 16'hFFFF, 1'b1);
        end
        send_level(8'hC3, 16'h1234, 1'b0);

        for (int p = 0; p < NumPhases; p++) begin
            case (p)
                0: configure(1'b1, RstFullLimit, RstFaultLimit, RstStartLow, RstStartHigh);
                1: configure(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: configure(1'b0, 16'($urandom_range(0, 1000)),
                             16'($urandom_range(1000, 5000)),
                             16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 5000)));
                4: configure(1'b1, 16'($urandom_range(0, 1000)),
                             16'($urandom_range(1000, 5000)),
                             16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 5000)));
                default: configure(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            for (int n = 0; n < ItemsPerPhase; n++) begin
                // Receiver-heavy idling first, then sender-heavy, then none at all.
                if (item_index < 500) begin
                    send_idle_pct = 21;
                    recv_idle_pct = 54;
                end else if (item_index < 1000) begin
                    send_idle_pct = 54;
                    recv_idle_pct = 21;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // Long receiver hold-off while the sender keeps offering, so the result
                // register fills and the input channel backs up.
                if (item_index == 250 || item_index == 1200) begin
                    hold_left = HoldCycles;
                end
                if (slot == 0) begin
                    center = pick_center();
                end
                random_frame();
                slot = (slot == DefWindowSize) ? 0 : slot + 1;
                item_index++;
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("level_frame_trimmed_mean_switch: match");
        end else begin
            $display("level_frame_trimmed_mean_switch: mismatch");
        end
        $finish;
    end

endmodule
